// ===== sv/lrs_pkg.sv =====
// ============================================================================
// lrs_pkg
// Shared types, register codes and the sigmoid table builder for the
// logistic regression scorer.
// ============================================================================
package lrs_pkg;

    localparam int FEAT_CNT = 6;
    localparam int FEAT_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = FEAT_W + WEIGHT_W;
    // six products of at most 2^30 plus the raised bias stay below 2^33
    localparam int SUM_W    = 35;
    localparam int SAT_W    = 24;
    localparam int PROB_W   = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes: weights sit at 0 .. FEAT_CNT-1, bias after them
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS = 3'd6;

    localparam logic [WEIGHT_W-1:0] BIAS_RST = 16'd410;

    typedef logic [FEAT_CNT-1:0][WEIGHT_W-1:0] t_weight_vec;
    typedef logic [FEAT_CNT-1:0][FEAT_W-1:0]   t_feat_vec;

    localparam t_weight_vec WEIGHT_RST = {
        16'd82, 16'd82, 16'd328, 16'hFF33, 16'd164, 16'd246
    };

    typedef struct packed {
        logic [15:0] junction_id;
        logic [47:0] stamp_ms;
    } t_tag;

    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] SUM_LIMIT = 64'd1 << 23;

    // shift-subtract division, used only while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num,
                                            input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-a, a in Q20, result in Q30: series of e^-(a/16), then squared four times
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
        logic [63:0]        u;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        e;
        u    = a << 6;
        term = Q30_ONE;
        acc  = $signed(Q30_ONE);
        for (int n = 1; n <= 12; n++) begin
            term = (term * u) >> 30;
            term = div_u64(term, 64'(n));
            if ((n % 2) == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        e = acc;
        for (int i = 0; i < 4; i++) begin
            e = (e * e) >> 30;
        end
        return e;
    endfunction

    // sigmoid at the center of bin k, rounded into Q0.16
    function automatic logic [PROB_W-1:0] sig_entry(input int k, input int depth);
        logic [63:0] cu;
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] p;
        logic        pos;
        cu  = div_u64(64'(2 * k + 1) << 24, 64'(2 * depth));
        pos = (cu >= SUM_LIMIT);
        a   = pos ? (cu - SUM_LIMIT) : (SUM_LIMIT - cu);
        e   = exp_neg_q30(a);
        d   = Q30_ONE + e;
        if (pos) begin
            p = div_u64((64'd1 << 46) + (d >> 1), d);
        end else begin
            p = div_u64((e << 16) + (d >> 1), d);
        end
        if (p > 64'd65535) begin
            p = 64'd65535;
        end
        return p[PROB_W-1:0];
    endfunction

endpackage

// ===== sv/lrs_cell.sv =====
// ============================================================================
// lrs_cell
// One multiply-accumulate cell: adds feature times weight to the running sum
// and hands the sum, the remaining features and the tag to the next cell.
// ============================================================================
module lrs_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [lrs_pkg::SUM_W-1:0] i_sum,
    input  lrs_pkg::t_feat_vec            i_feat,
    input  lrs_pkg::t_tag                 i_tag,
    input  logic [lrs_pkg::WEIGHT_W-1:0]  i_weight,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [lrs_pkg::SUM_W-1:0] o_sum,
    output lrs_pkg::t_feat_vec            o_feat,
    output lrs_pkg::t_tag                 o_tag
);

    logic                                r_valid;
    logic signed [lrs_pkg::SUM_W-1:0]    r_sum;
    lrs_pkg::t_feat_vec                  r_feat;
    lrs_pkg::t_tag                       r_tag;
    logic signed [lrs_pkg::PROD_W-1:0]   w_prod;
    logic                                w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;
    assign w_prod  = $signed(i_feat[0]) * $signed(i_weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // feature zero is consumed here, the rest move down one slot
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sum  <= i_sum + lrs_pkg::SUM_W'(w_prod);
            r_feat <= {{lrs_pkg::FEAT_W{1'b0}}, i_feat[lrs_pkg::FEAT_CNT-1:1]};
            r_tag  <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;
    assign o_feat  = r_feat;
    assign o_tag   = r_tag;

endmodule

// ===== sv/lrs_sigmoid.sv =====
// ============================================================================
// lrs_sigmoid
// Saturates the score to [-8, 8), forms the table index, then reads the
// sigmoid table into the output register.
// ============================================================================
module lrs_sigmoid #(
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [lrs_pkg::SUM_W-1:0] i_sum,
    input  lrs_pkg::t_tag                    i_tag,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lrs_pkg::PROB_W-1:0]       o_prob,
    output lrs_pkg::t_tag                    o_tag
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int DEP_W = $clog2(DEPTH + 1);
    localparam int MUL_W = lrs_pkg::SAT_W + DEP_W;

    logic [lrs_pkg::PROB_W-1:0] w_rom [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        localparam logic [lrs_pkg::PROB_W-1:0] ROM_VAL = lrs_pkg::sig_entry(k, DEPTH);
        assign w_rom[k] = ROM_VAL;
    end

    logic                        r_a_valid;
    logic [IDX_W-1:0]            r_a_idx;
    lrs_pkg::t_tag               r_a_tag;
    logic                        r_b_valid;
    logic [lrs_pkg::PROB_W-1:0]  r_b_prob;
    lrs_pkg::t_tag               r_b_tag;

    logic                        w_a_ready;
    logic                        w_b_ready;
    logic                        w_in_range;
    logic [lrs_pkg::SAT_W-1:0]   w_sat;
    logic [lrs_pkg::SAT_W-1:0]   w_offs;
    logic [MUL_W-1:0]            w_scaled;

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    // in range when all bits above the 24-bit window match its sign
    assign w_in_range = (i_sum[lrs_pkg::SUM_W-1:lrs_pkg::SAT_W-1] == '0)
                     || (i_sum[lrs_pkg::SUM_W-1:lrs_pkg::SAT_W-1] == '1);

    always_comb begin
        if (w_in_range) begin
            w_sat = i_sum[lrs_pkg::SAT_W-1:0];
        end else if (i_sum[lrs_pkg::SUM_W-1]) begin
            w_sat = {1'b1, {(lrs_pkg::SAT_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(lrs_pkg::SAT_W-1){1'b1}}};
        end
    end

    // adding 2^23 flips the sign bit
    assign w_offs   = {~w_sat[lrs_pkg::SAT_W-1], w_sat[lrs_pkg::SAT_W-2:0]};
    assign w_scaled = MUL_W'(w_offs) * MUL_W'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_a_ready) begin
            r_a_idx <= w_scaled[lrs_pkg::SAT_W +: IDX_W];
            r_a_tag <= i_tag;
        end
        if (r_a_valid && w_b_ready) begin
            r_b_prob <= w_rom[r_a_idx];
            r_b_tag  <= r_a_tag;
        end
    end

    assign o_valid = r_b_valid;
    assign o_prob  = r_b_prob;
    assign o_tag   = r_b_tag;

endmodule

// ===== sv/logistic_regression_scorer.sv =====
// ============================================================================
// logistic_regression_scorer
// Six-feature logistic regression: a row of multiply-accumulate cells, a
// saturate and index stage, and a registered sigmoid table lookup.
// ============================================================================
//  channel   dir  signals                              transfer when
//  ------    ---  -----------------------------------  -----------------------
//  s (in)    in   i_s_tvalid o_s_tready i_s_tdata      i_s_tvalid & o_s_tready
//  m (out)   out  o_m_tvalid i_m_tready o_m_tdata      o_m_tvalid & i_m_tready
//  cfg       in   i_cfg_we i_cfg_idx i_cfg_wdata       i_cfg_we
//
//  one record per cycle unless the output stalls; a stage per feature cell,
//  then saturation and index, then the table read into the output register
//  every stage holds its own valid bit and takes a new record when empty or
//  when its successor moves, so bubbles close up under output stalls
//  synchronous active-low reset empties the pipeline and loads the default
//  weights and bias; the sigmoid table is constant logic
// ============================================================================
module logistic_regression_scorer #(
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_wdata,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // feat_zero, feat_one, feat_two, feat_three, feat_four, feat_five,
    // stamp_ms, junction_id
    input  logic [159:0] i_s_tdata,
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // out_stamp_ms, out_junction_id, probability
    output logic [79:0]  o_m_tdata
);

    localparam int NSTG = lrs_pkg::FEAT_CNT;
    localparam int FW   = lrs_pkg::FEAT_CNT * lrs_pkg::FEAT_W;

    lrs_pkg::t_weight_vec             r_weight;
    logic [lrs_pkg::WEIGHT_W-1:0]     r_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= lrs_pkg::WEIGHT_RST;
            r_bias   <= lrs_pkg::BIAS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < lrs_pkg::CFG_IDX_W'(lrs_pkg::FEAT_CNT)) begin
                r_weight[i_cfg_idx] <= i_cfg_wdata;
            end else if (i_cfg_idx == lrs_pkg::CFG_BIAS) begin
                r_bias <= i_cfg_wdata;
            end
        end
    end

    logic                              w_vld  [NSTG+1];
    logic                              w_rdy  [NSTG+1];
    logic signed [lrs_pkg::SUM_W-1:0]  w_sum  [NSTG+1];
    lrs_pkg::t_feat_vec                w_feat [NSTG+1];
    lrs_pkg::t_tag                     w_tag  [NSTG+1];
    logic [lrs_pkg::PROB_W-1:0]        w_prob;
    lrs_pkg::t_tag                     w_out_tag;

    // bias in Q4.12 raised to Q15.20
    assign w_vld[0]  = i_s_tvalid;
    assign w_sum[0]  = {{(lrs_pkg::SUM_W-24){r_bias[15]}}, r_bias, 8'h00};
    assign w_feat[0] = i_s_tdata[FW-1:0];
    assign w_tag[0]  = '{stamp_ms:    i_s_tdata[FW +: 48],
                         junction_id: i_s_tdata[FW+48 +: 16]};
    assign o_s_tready = w_rdy[0];

    for (genvar k = 0; k < NSTG; k++) begin : g_cell
        lrs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_vld[k]),
            .o_ready  (w_rdy[k]),
            .i_sum    (w_sum[k]),
            .i_feat   (w_feat[k]),
            .i_tag    (w_tag[k]),
            .i_weight (r_weight[k]),
            .o_valid  (w_vld[k+1]),
            .i_ready  (w_rdy[k+1]),
            .o_sum    (w_sum[k+1]),
            .o_feat   (w_feat[k+1]),
            .o_tag    (w_tag[k+1])
        );
    end

    lrs_sigmoid #(
        .DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_sigmoid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[NSTG]),
        .o_ready (w_rdy[NSTG]),
        .i_sum   (w_sum[NSTG]),
        .i_tag   (w_tag[NSTG]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_prob  (w_prob),
        .o_tag   (w_out_tag)
    );

    assign o_m_tdata = {w_prob, w_out_tag.junction_id, w_out_tag.stamp_ms};

    // an output that is empty or being taken lets readiness reach the input
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled while output side can move");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result present right after reset");

    // the features reaching the sigmoid stage are all zero, each consumed by a cell
    a_feat_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[NSTG] |-> (w_feat[NSTG] == '0))
        else $error("features not consumed by the cell row");

endmodule
